// ===== rtl/core/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

  typedef struct packed {
    logic signed [15:0] hue;
    logic [7:0]         alpha_in;
  } hsv_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
  } rgb_item_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SATURATION  = 2'd0,
    REG_VALUE_LEVEL = 2'd1
  } cfg_reg_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] SATURATION_RST  = 8'd217;
  localparam logic [7:0] VALUE_LEVEL_RST = 8'd255;

  // 60-degree sectors of the color wheel
  typedef enum logic [2:0] {
    SEC_RED_YELLOW     = 3'd0,
    SEC_YELLOW_GREEN   = 3'd1,
    SEC_GREEN_CYAN     = 3'd2,
    SEC_CYAN_BLUE      = 3'd3,
    SEC_BLUE_MAGENTA   = 3'd4,
    SEC_MAGENTA_RED    = 3'd5
  } hue_sector_t;

  // Multiple of 360 that lifts any 16-bit signed hue to a non-negative value
  localparam logic [16:0] HUE_BIAS   = 17'd33120;
  localparam logic [8:0]  FULL_TURN  = 9'd360;
  localparam logic [5:0]  SECTOR_DEG = 6'd60;
  localparam logic [7:0]  UNIT_MAX   = 8'd255;
  localparam logic [13:0] MID_MAX    = 14'd15300;

  // Reciprocals, rounded up: floor(x*R >> sh) is exact over each operand range
  localparam logic [17:0] RECIP_360   = 18'd186414;   // shift 26, x < 2^17
  localparam logic [10:0] RECIP_60    = 11'd1093;     // shift 16, x < 360
  localparam logic [22:0] RECIP_15300 = 23'd4491470;  // shift 36, x < 2^22
  localparam logic [16:0] RECIP_255   = 17'd65794;    // shift 24, x < 65026

endpackage

// ===== rtl/core/hsv_to_rgb_converter_top.sv =====
// HSV to RGB converter: takes one item per clock while not stalled (hue in
// degrees, any 16-bit signed value, plus an alpha byte) and returns one RGB
// item per item, with alpha copied through. Saturation and value are 8-bit
// fractions of 255 set by the configuration port (index 0 saturation, reset
// 217; index 1 value_level, reset 255); write them only while no item is in
// flight. Sustained rate is one item per cycle while the output is not stalled.
// The five register stages are: hue reduction quotient, sector and offset, mid
// weight, products with value, reciprocal divides plus channel selection into
// the output register. A stall on the output freezes every stage at once, so
// in_stall follows out_stall whenever the output register holds an item.
module hsv_to_rgb_converter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hsv2rgb_pkg::hsv_item_t            in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hsv2rgb_pkg::rgb_item_t            out_data,
  input  logic                              cfg_we,
  input  logic [hsv2rgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsv2rgb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Stage payloads
  typedef struct packed {
    logic [16:0] biased;   // hue lifted to non-negative
    logic [7:0]  quot;     // biased / 360
    logic [7:0]  alpha;
  } st1_t;

  typedef struct packed {
    hsv2rgb_pkg::hue_sector_t sector;
    logic [5:0]               k;      // weight toward the rising/falling channel
    logic [7:0]               alpha;
  } st2_t;

  typedef struct packed {
    hsv2rgb_pkg::hue_sector_t sector;
    logic [13:0]              w;      // s*k + 60*(255-s)
    logic [7:0]               alpha;
  } st3_t;

  typedef struct packed {
    hsv2rgb_pkg::hue_sector_t sector;
    logic [21:0]              mid_num;
    logic [15:0]              bot_num;
    logic [7:0]               alpha;
  } st4_t;

  // Configuration registers
  logic [7:0] sat_r, val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= hsv2rgb_pkg::SATURATION_RST;
      val_r <= hsv2rgb_pkg::VALUE_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hsv2rgb_pkg::REG_SATURATION:  sat_r <= cfg_wdata;
        hsv2rgb_pkg::REG_VALUE_LEVEL: val_r <= cfg_wdata;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // One enable for the whole pipe: advance unless the output item is held.
  logic advance;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  st4_t s4_r, s4_nxt;
  hsv2rgb_pkg::rgb_item_t out_r, out_nxt;

  assign advance   = !(out_valid_r && out_stall);
  assign in_stall  = !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Stage 1: bias the hue and take the quotient by 360 via reciprocal.
  logic [34:0] quot_prod;
  always_comb begin
    s1_nxt.biased = {in_data.hue[15], in_data.hue} + hsv2rgb_pkg::HUE_BIAS;
    quot_prod     = 35'(s1_nxt.biased) * 35'(hsv2rgb_pkg::RECIP_360);
    s1_nxt.quot   = quot_prod[33:26];
    s1_nxt.alpha  = in_data.alpha_in;
  end

  // Stage 2: residue 0..359, then sector and offset within the sector.
  logic [16:0] hue_full;
  logic [8:0]  hue_mod;
  logic [19:0] sec_prod;
  logic [8:0]  off_full;
  logic [5:0]  off;
  always_comb begin
    hue_full      = s1_r.biased - 17'(s1_r.quot) * 17'(hsv2rgb_pkg::FULL_TURN);
    hue_mod       = hue_full[8:0];
    sec_prod      = 20'(hue_mod) * 20'(hsv2rgb_pkg::RECIP_60);
    s2_nxt.sector = hsv2rgb_pkg::hue_sector_t'(sec_prod[18:16]);
    off_full      = hue_mod - 9'(sec_prod[18:16]) * 9'(hsv2rgb_pkg::SECTOR_DEG);
    off           = off_full[5:0];
    // Odd sectors run the mid channel downward.
    s2_nxt.k      = sec_prod[16] ? 6'(hsv2rgb_pkg::SECTOR_DEG - off) : off;
    s2_nxt.alpha  = s1_r.alpha;
  end

  // Stage 3: mid weight, s*k + 60*(255-s), at most 15300.
  always_comb begin
    s3_nxt.sector = s2_r.sector;
    s3_nxt.w      = 14'(sat_r) * 14'(s2_r.k)
                  + 14'(hsv2rgb_pkg::SECTOR_DEG) * 14'(hsv2rgb_pkg::UNIT_MAX - sat_r);
    s3_nxt.alpha  = s2_r.alpha;
  end

  // Stage 4: scale by value.
  always_comb begin
    s4_nxt.sector  = s3_r.sector;
    s4_nxt.mid_num = 22'(val_r) * 22'(s3_r.w);
    s4_nxt.bot_num = 16'(val_r) * 16'(hsv2rgb_pkg::UNIT_MAX - sat_r);
    s4_nxt.alpha   = s3_r.alpha;
  end

  // Stage 5: exact divides by 15300 and 255, then route channels by sector.
  logic [44:0] mid_prod;
  logic [32:0] bot_prod;
  logic [7:0]  mid, bot, top;
  always_comb begin
    mid_prod = 45'(s4_r.mid_num) * 45'(hsv2rgb_pkg::RECIP_15300);
    bot_prod = 33'(s4_r.bot_num) * 33'(hsv2rgb_pkg::RECIP_255);
    mid      = mid_prod[43:36];
    bot      = bot_prod[31:24];
    top      = val_r;
    out_nxt.alpha_out = s4_r.alpha;
    case (s4_r.sector)
      hsv2rgb_pkg::SEC_RED_YELLOW:   begin
        out_nxt.red = top; out_nxt.green = mid; out_nxt.blue = bot;
      end
      hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
        out_nxt.red = mid; out_nxt.green = top; out_nxt.blue = bot;
      end
      hsv2rgb_pkg::SEC_GREEN_CYAN:   begin
        out_nxt.red = bot; out_nxt.green = top; out_nxt.blue = mid;
      end
      hsv2rgb_pkg::SEC_CYAN_BLUE:    begin
        out_nxt.red = bot; out_nxt.green = mid; out_nxt.blue = top;
      end
      hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
        out_nxt.red = mid; out_nxt.green = bot; out_nxt.blue = top;
      end
      default: begin
        out_nxt.red = top; out_nxt.green = bot; out_nxt.blue = mid;
      end
    endcase
  end

  // Valid bits travel with the data; hold everything while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      out_r <= out_nxt;
    end
  end

  // Checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid right after reset");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (s2_r.sector <= hsv2rgb_pkg::SEC_MAGENTA_RED && s2_r.k <= hsv2rgb_pkg::SECTOR_DEG))
    else $error("sector or offset out of range");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> s3_r.w <= hsv2rgb_pkg::MID_MAX)
    else $error("mid weight exceeds 15300");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(v4_r) && $stable(s4_r)))
    else $error("inner stage moved while output stalled");

endmodule
